>>> hw/rtl/stable_max_priority_queue_macros.svh
// Assertion macros used by the checker of this block.
`ifndef STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH

// Clocked check, off while reset is held.
`define SMPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define SMPQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/smpq_pkg.sv
package smpq_pkg;

    localparam int SEV_W = 16;
    localparam int TAG_W = 16;
    localparam int STS_W = 2;

    // op codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // status codes
    localparam logic [STS_W-1:0] STS_SERVED   = 2'd0;
    localparam logic [STS_W-1:0] STS_INSERTED = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd2;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd3;

    typedef struct packed {
        logic [SEV_W-1:0] sev;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [TAG_W-1:0] tag;
        logic [SEV_W-1:0] sev;
    } t_result;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD   = 7'b0000010,
        ST_CMP  = 7'b0000100,
        ST_PUT  = 7'b0001000,
        ST_HRD  = 7'b0010000,
        ST_HEAD = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

endpackage

>>> hw/rtl/smpq_if.sv
interface smpq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [smpq_pkg::SEV_W-1:0]  severity;
    logic [smpq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, output op, output severity, output tag, input ready);
    modport sink   (input valid, input op, input severity, input tag, output ready);
endinterface

interface smpq_out_if;
    logic                        valid;
    logic                        ready;
    logic [smpq_pkg::STS_W-1:0]  status;
    logic [smpq_pkg::TAG_W-1:0]  served_tag;
    logic [smpq_pkg::SEV_W-1:0]  served_severity;

    modport source (output valid, output status, output served_tag,
                    output served_severity, input ready);
    modport sink   (input valid, input status, input served_tag,
                    input served_severity, output ready);
endinterface

>>> hw/rtl/smpq_store.sv
// Entry memory: one write port, one read port, registered read data.
module smpq_store #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  smpq_pkg::t_entry         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output smpq_pkg::t_entry         o_rd_data
);

    smpq_pkg::t_entry r_mem [DEPTH];
    smpq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/stable_max_priority_queue.sv
// Channel   Dir  Fields                                   Handshake
// i_in      in   op, severity, tag                        valid / ready
// o_out     out  status, served_tag, served_severity      valid / ready
//
// One word in gives one word out. A word is taken only in the idle state.
// Serve reads the head entry, then moves the head. An insert walks from the tail
// toward the head: each stored entry of lower severity is read, compared and
// moved one slot toward the tail, then the new entry is written into the hole.
// A rejected insert or an empty serve goes straight to the done state.
// Synchronous active-low reset empties the queue; memory contents are kept.
// A finished result waits in the done state only while the output register
// still holds an untaken word; the output register accepts a new word while
// a stalled one is being taken.
module stable_max_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    smpq_in_if.sink           i_in,
    smpq_out_if.source        o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_SUM = (AW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Control state
    smpq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;       // stored entries
    logic [AW-1:0]     r_head, n_head;     // slot of the best entry (ring)
    logic              r_out_valid, n_out_valid;

    // Working registers
    logic [AW-1:0]                r_idx, n_idx;   // logical slot being filled
    logic [smpq_pkg::SEV_W-1:0]   r_sev, n_sev;
    logic [smpq_pkg::TAG_W-1:0]   r_tag, n_tag;
    smpq_pkg::t_result            r_res, n_res;
    smpq_pkg::t_result            r_out, n_out;

    // Shared ring-address unit: logical slot -> physical slot
    logic [AW-1:0] u_lidx;
    logic [AW:0]   u_sum;
    logic [AW-1:0] u_phys;

    // Memory port
    logic              mem_wr_en;
    smpq_pkg::t_entry  mem_wr_data;
    smpq_pkg::t_entry  mem_rd_data;
    smpq_pkg::t_entry  new_entry;
    logic              out_free;

    assign u_sum  = {1'b0, r_head} + {1'b0, u_lidx};
    assign u_phys = (u_sum >= CAP_SUM) ? AW'(u_sum - CAP_SUM) : u_sum[AW-1:0];

    assign new_entry = '{sev: r_sev, tag: r_tag};
    assign out_free  = !r_out_valid || o_out.ready;

    smpq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (u_phys),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (u_phys),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_head      = r_head;
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        n_sev       = r_sev;
        n_tag       = r_tag;
        n_res       = r_res;
        n_out       = r_out;
        u_lidx      = r_idx;
        mem_wr_en   = 1'b0;
        mem_wr_data = new_entry;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            smpq_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_sev = i_in.severity;
                    n_tag = i_in.tag;
                    if (i_in.op == smpq_pkg::OP_INSERT) begin
                        if (r_occ == CAP_CNT) begin
                            n_res   = '{status: smpq_pkg::STS_FULL, tag: '0, sev: '0};
                            n_state = smpq_pkg::ST_DONE;
                        end else if (r_occ == '0) begin
                            n_idx   = '0;
                            n_state = smpq_pkg::ST_PUT;
                        end else begin
                            // start at the tail and walk toward the head
                            n_idx   = r_occ[AW-1:0];
                            n_state = smpq_pkg::ST_RD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_res   = '{status: smpq_pkg::STS_EMPTY, tag: '0, sev: '0};
                            n_state = smpq_pkg::ST_DONE;
                        end else begin
                            n_state = smpq_pkg::ST_HRD;
                        end
                    end
                end
            end
            smpq_pkg::ST_RD: begin
                // fetch the neighbor in front of the hole
                u_lidx  = r_idx - AW'(1);
                n_state = smpq_pkg::ST_CMP;
            end
            smpq_pkg::ST_CMP: begin
                u_lidx = r_idx;
                if (mem_rd_data.sev >= r_sev) begin
                    // equal severity stays ahead: ties keep arrival order
                    n_state = smpq_pkg::ST_PUT;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data;
                    n_idx       = r_idx - AW'(1);
                    n_state     = (r_idx == AW'(1)) ? smpq_pkg::ST_PUT : smpq_pkg::ST_RD;
                end
            end
            smpq_pkg::ST_PUT: begin
                u_lidx    = r_idx;
                mem_wr_en = 1'b1;
                n_occ     = r_occ + CW'(1);
                n_res     = '{status: smpq_pkg::STS_INSERTED, tag: '0, sev: '0};
                n_state   = smpq_pkg::ST_DONE;
            end
            smpq_pkg::ST_HRD: begin
                u_lidx  = '0;
                n_state = smpq_pkg::ST_HEAD;
            end
            smpq_pkg::ST_HEAD: begin
                // head moves one slot around the ring
                u_lidx  = AW'(1);
                n_head  = u_phys;
                n_occ   = r_occ - CW'(1);
                n_res   = '{status: smpq_pkg::STS_SERVED,
                            tag: mem_rd_data.tag, sev: mem_rd_data.sev};
                n_state = smpq_pkg::ST_DONE;
            end
            smpq_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = smpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smpq_pkg::ST_IDLE;
            r_occ       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_sev <= n_sev;
        r_tag <= n_tag;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_in.ready            = (r_state == smpq_pkg::ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.served_tag      = r_out.tag;
    assign o_out.served_severity = r_out.sev;

endmodule

>>> hw/rtl/smpq_checker.sv
`include "stable_max_priority_queue_macros.svh"

module smpq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [smpq_pkg::STS_W-1:0]  i_out_status,
    input logic [smpq_pkg::TAG_W-1:0]  i_out_tag,
    input logic [smpq_pkg::SEV_W-1:0]  i_out_sev
);

    // output word holds while stalled
    `SMPQ_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "output word dropped")
    `SMPQ_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_status) && $stable(i_out_tag) && $stable(i_out_sev), "output word changed")

    // only a served word carries an entry
    `SMPQ_ASSERT(a_zero_fields, i_out_valid && (i_out_status != smpq_pkg::STS_SERVED) |-> (i_out_tag == '0) && (i_out_sev == '0), "nonzero fields on non-serve")

    // one word at a time: busy right after taking a word
    `SMPQ_ASSERT(a_busy_after_take, i_in_valid && i_in_ready |=> !i_in_ready, "ready held after accept")

    // reset clears the output side
    `SMPQ_ASSERT_RST(a_reset_out, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind stable_max_priority_queue smpq_checker u_smpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_tag    (o_out.served_tag),
    .i_out_sev    (o_out.served_severity)
);
